// ===== rtl/dtb_pkg.sv =====
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared types and constants for the DMA descriptor table builder.
// ----------------------------------------------------------------------------
package dtb_pkg;

    localparam int RESULT_CAP = 17;
    localparam int RUN_W      = 5;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_ADDR  = 2'd1;
    localparam logic [1:0] ERR_SLOTS = 2'd2;
    localparam logic [1:0] ERR_TOTAL = 2'd3;

    typedef struct packed {
        logic [47:0] segment_address;
        logic [16:0] segment_length;
        logic        last_segment;
    } t_seg_in;

    typedef struct packed {
        logic [31:0] region_address;
        logic [15:0] region_bytes;
        logic        end_of_table;
        logic [4:0]  slot_index;
        logic        last_of_run;
        logic [1:0]  error_code;
        logic [16:0] total_bytes;
    } t_desc_out;

endpackage

// ===== rtl/dtb_front.sv =====
// ----------------------------------------------------------------------------
// dtb_front
// Accepts segment items and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module dtb_front
    import dtb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_seg_valid,
    output logic    o_seg_ready,
    input  t_seg_in i_seg,
    output logic    o_q_valid,
    input  logic    i_q_pop,
    output t_seg_in o_q_seg
);

    t_seg_in    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_seg_ready = (r_count != 2'd2);
    assign o_q_valid   = (r_count != 2'd0);
    assign o_q_seg     = r_mem[r_rd_ptr];
    assign push        = i_seg_valid && o_seg_ready;
    assign pop         = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_push_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count != 2'd0))
    else $error("queue count lost a push");

endmodule

// ===== rtl/dtb_engine.sv =====
// ----------------------------------------------------------------------------
// dtb_engine
// Splits one queued segment at page boundaries, one descriptor per cycle
// when not stalled, tracking slot count, byte total and request sticky error.
// ----------------------------------------------------------------------------
module dtb_engine
    import dtb_pkg::*;
#(
    parameter int PAGE_SIZE    = 4096,
    parameter int MAX_SLOTS    = 17,
    parameter int MAX_TRANSFER = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    output logic      o_q_pop,
    input  t_seg_in   i_q_seg,
    output logic      o_desc_valid,
    input  logic      i_desc_ready,
    output t_desc_out o_desc
);

    // PAGE_SIZE must be a power of two; the engine does not check it
    localparam int PAGE_W     = $clog2(PAGE_SIZE);
    localparam int SLOT_LIMIT = (MAX_SLOTS < 31) ? MAX_SLOTS : 31;
    localparam int TOTAL_RAW  = MAX_TRANSFER + PAGE_SIZE;
    localparam int TOTAL_CAP  = (TOTAL_RAW < 131071) ? TOTAL_RAW : 131071;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state         r_state;
    logic [47:0]    r_addr;
    logic [16:0]    r_remain;
    logic           r_last;
    logic [RUN_W-1:0] r_n;
    logic [4:0]     r_slot;
    logic [16:0]    r_total;
    logic [1:0]     r_err;
    logic           r_out_valid;
    t_desc_out      r_out;

    logic [16:0]    room;
    logic [16:0]    piece;
    logic           cap_hit;
    logic           done;
    logic           addr_hi;
    logic           slot_full;
    logic [4:0]     slot;
    logic [17:0]    tot_raw;
    logic           tot_over;
    logic [16:0]    tot;
    logic [1:0]     n_err;
    logic           emit;

    assign o_q_pop      = (r_state == ST_IDLE);
    assign emit         = (r_state == ST_RUN) && (!r_out_valid || i_desc_ready);
    assign o_desc_valid = r_out_valid;
    assign o_desc       = r_out;

    always_comb begin
        room    = 17'(PAGE_SIZE) - 17'(r_addr[PAGE_W-1:0]);
        piece   = (r_remain < room) ? r_remain : room;
        cap_hit = (r_n == RUN_W'(RESULT_CAP - 1)) && (piece < r_remain);
        if (cap_hit) begin
            piece = r_remain;
        end
        done      = (piece == r_remain);
        addr_hi   = ({1'b0, r_addr} + 49'(piece)) > 49'h1_0000_0000;
        slot_full = (r_slot >= 5'(SLOT_LIMIT));
        slot      = slot_full ? 5'(SLOT_LIMIT - 1) : r_slot;
        tot_raw   = 18'(r_total) + 18'(piece);
        tot_over  = tot_raw > 18'(MAX_TRANSFER);
        tot       = (tot_raw > 18'(TOTAL_CAP)) ? 17'(TOTAL_CAP) : tot_raw[16:0];
        if (r_err != ERR_NONE) begin
            n_err = r_err;
        end else if (cap_hit) begin
            n_err = ERR_SLOTS;
        end else if (addr_hi) begin
            n_err = ERR_ADDR;
        end else if (slot_full) begin
            n_err = ERR_SLOTS;
        end else if (tot_over) begin
            n_err = ERR_TOTAL;
        end else begin
            n_err = ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= 5'd0;
            r_total     <= 17'd0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
            r_n         <= '0;
        end else begin
            if (r_out_valid && i_desc_ready && !emit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_addr   <= i_q_seg.segment_address;
                        r_remain <= i_q_seg.segment_length;
                        r_last   <= i_q_seg.last_segment;
                        r_n      <= '0;
                        r_state  <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (emit) begin
                        r_out_valid          <= 1'b1;
                        r_out.region_address <= r_addr[31:0];
                        r_out.region_bytes   <= piece[15:0];
                        r_out.end_of_table   <= done && r_last;
                        r_out.slot_index     <= slot;
                        r_out.last_of_run    <= done;
                        r_out.error_code     <= n_err;
                        r_out.total_bytes    <= tot;
                        r_addr   <= r_addr + 48'(piece);
                        r_remain <= r_remain - piece;
                        r_n      <= r_n + RUN_W'(1);
                        if (done && r_last) begin
                            r_slot  <= 5'd0;
                            r_total <= 17'd0;
                            r_err   <= ERR_NONE;
                        end else begin
                            r_slot  <= slot_full ? r_slot : r_slot + 5'd1;
                            r_total <= tot;
                            r_err   <= n_err;
                        end
                        if (done) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_n <= RUN_W'(RESULT_CAP - 1)))
    else $error("segment produced too many descriptors");

    a_req_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && done && r_last) |=>
            (r_slot == 5'd0 && r_total == 17'd0 && r_err == ERR_NONE))
    else $error("request state not cleared after last segment");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE && !(emit && done && r_last)) |=> $stable(r_err))
    else $error("sticky error changed within request");

    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= 17'(TOTAL_CAP))
    else $error("byte total above its cap");

endmodule

// ===== rtl/dma_descriptor_table_builder.sv =====
// ----------------------------------------------------------------------------
// dma_descriptor_table_builder
// Cuts scatter-gather segments into page-bounded physical region descriptors.
// ----------------------------------------------------------------------------
// Input channel (i_seg_valid / o_seg_ready, i_seg): one segment item per
// handshake, with address, length and last-segment flag. Items land in a
// two-entry queue, so up to two segments are taken while the engine works.
// Output channel (o_desc_valid / i_desc_ready, o_desc): one descriptor item
// per page piece, in order, with slot, running total and sticky error.
// The first descriptor of a segment, when the engine is idle, passes the
// queue entry, the engine's load from the queue and the output register.
// A segment of N pieces takes one engine step to load it from the queue and
// one per descriptor; the next segment is loaded only after its last piece.
// A stalled receiver holds the output register; the engine waits behind it
// and the queue keeps taking items until full.
// Reset clears the queue, the output register and the request state.
// PAGE_SIZE must be a power of two.
// ----------------------------------------------------------------------------
module dma_descriptor_table_builder
    import dtb_pkg::*;
#(
    parameter int PAGE_SIZE    = 4096,
    parameter int MAX_SLOTS    = 17,
    parameter int MAX_TRANSFER = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_seg_valid,
    output logic      o_seg_ready,
    input  t_seg_in   i_seg,
    output logic      o_desc_valid,
    input  logic      i_desc_ready,
    output t_desc_out o_desc
);

    logic    q_valid;
    logic    q_pop;
    t_seg_in q_seg;

    dtb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_valid (i_seg_valid),
        .o_seg_ready (o_seg_ready),
        .i_seg       (i_seg),
        .o_q_valid   (q_valid),
        .i_q_pop     (q_pop),
        .o_q_seg     (q_seg)
    );

    dtb_engine #(
        .PAGE_SIZE    (PAGE_SIZE),
        .MAX_SLOTS    (MAX_SLOTS),
        .MAX_TRANSFER (MAX_TRANSFER)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_q_seg      (q_seg),
        .o_desc_valid (o_desc_valid),
        .i_desc_ready (i_desc_ready),
        .o_desc       (o_desc)
    );

endmodule
